/* rtl/pocsag_text_codeword_encoder_macros.svh */
// Assertion macros shared by the POCSAG text encoder modules.
`ifndef POCSAG_TEXT_CODEWORD_ENCODER_MACROS_SVH
`define POCSAG_TEXT_CODEWORD_ENCODER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define PTCE_ASSERT_IMPL(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define PTCE_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

/* rtl/ptce_pkg.sv */
// Shared types, constants and the BCH column function of the POCSAG text encoder.
package ptce_pkg;

	// Codeword layout
	localparam int unsigned WORD_BITS  = 20;
	localparam int unsigned DATA_BITS  = 21;
	localparam int unsigned CHECK_BITS = 10;
	localparam int unsigned CHAR_BITS  = 7;

	localparam logic [31:0] BCH_POLY = 32'hED20_0000;
	localparam logic [6:0]  EOT_CHAR = 7'h04;
	localparam logic [5:0]  SLOT_MAX = 6'd63;
	localparam logic        MSG_FLAG = 1'b1;
	localparam logic        ADR_FLAG = 1'b0;

	// Configuration register indexes
	localparam int unsigned CFG_INDEX_BITS = 2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_PAGER_ADDRESS = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_FUNCTION_BITS = 2'd1;

	typedef struct packed {
		logic [7:0] text_char;
		logic       char_valid;
		logic       message_end;
	} ptce_item_t;

	typedef struct packed {
		logic [31:0] codeword;
		logic [5:0]  slot;
		logic        is_address;
		logic        last_word;
	} ptce_result_t;

	// Up to two results written into the output queue in one cycle
	typedef struct packed {
		logic [1:0]   count;
		ptce_result_t first;
		ptce_result_t second;
	} ptce_wr_t;

	// Check bits contributed by data bit k (codeword bit 11 + k)
	function automatic logic [CHECK_BITS-1:0] bch_column(input int unsigned k);
		logic [31:0] r;
		r = 32'h1 << (11 + k);
		for (int i = 0; i < 21; i++) begin
			if (r[31]) begin
				r = r ^ BCH_POLY;
			end
			r = r << 1;
		end
		return r[31:22];
	endfunction

endpackage

/* rtl/ptce_bch.sv */
// BCH(31,21) check bits and even parity for one codeword, as an XOR network.
module ptce_bch (
	input  logic [20:0] data,
	output logic [31:0] codeword
);
	import ptce_pkg::*;

	logic [CHECK_BITS-1:0] term [DATA_BITS];
	logic [CHECK_BITS-1:0] check;

	// Gate each data bit's constant syndrome column
	for (genvar k = 0; k < DATA_BITS; k++) begin : g_col
		localparam logic [CHECK_BITS-1:0] COL = bch_column(k);
		assign term[k] = data[k] ? COL : '0;
	end

	// Fold the columns
	always_comb begin
		check = '0;
		for (int k = 0; k < DATA_BITS; k++) begin
			check = check ^ term[k];
		end
	end

	// Append check bits and even parity over bits 31..1
	assign codeword = {data, check, ^{data, check}};

endmodule

/* rtl/ptce_pack.sv */
// Input register, bit packing, slot tracking and codeword build for one item.
`include "pocsag_text_codeword_encoder_macros.svh"
module ptce_pack #(
	parameter int unsigned MAX_TEXT_CHARS = 40
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ptce_pkg::ptce_item_t in_item,
	input  logic [20:0]         pager_address,
	input  logic [1:0]          function_bits,
	input  logic                room,
	output ptce_pkg::ptce_wr_t  wr
);
	import ptce_pkg::*;

	localparam logic [5:0] MAX_CHARS = 6'(MAX_TEXT_CHARS);

	function automatic logic [6:0] rev7(input logic [6:0] c);
		logic [6:0] r;
		for (int i = 0; i < 7; i++) begin
			r[6-i] = c[i];
		end
		return r;
	endfunction

	function automatic logic [5:0] slot_inc(input logic [5:0] s);
		return (s == SLOT_MAX) ? SLOT_MAX : s + 6'd1;
	endfunction

	ptce_item_t  item_s1;
	logic        valid_s1;
	logic [19:0] store_q;
	logic [4:0]  held_q;
	logic [5:0]  slot_q;
	logic        in_msg_q;
	logic [5:0]  taken_q;

	logic        adv;
	logic        start;
	logic        active;
	logic        take;
	logic        eot;
	logic [19:0] store0;
	logic [4:0]  held0;
	logic [5:0]  taken0;
	logic [5:0]  base_slot;
	logic [13:0] seq;
	logic [3:0]  n_bits;
	logic [33:0] acc;
	logic [5:0]  l_len;
	logic        full_e;
	logic        flush_e;
	logic [4:0]  rem_len;
	logic [19:0] full_data;
	logic [19:0] rem_bits;
	logic [19:0] flush_data;
	logic [19:0] msg_a;
	logic [5:0]  slot_full;
	logic [5:0]  slot_flush;
	logic [1:0]  n_res;
	logic [20:0] addr_data;
	logic [20:0] data0;
	logic [20:0] data1;
	logic [31:0] cw0;
	logic [31:0] cw1;

	// Item advances out of the input register when the queue has room for two results
	assign adv      = valid_s1 && room;
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	// Message start and the state seen by this item
	assign start     = !in_msg_q && (item_s1.char_valid || item_s1.message_end);
	assign active    = in_msg_q || start;
	assign store0    = start ? '0 : store_q;
	assign held0     = start ? '0 : held_q;
	assign taken0    = start ? '0 : taken_q;
	assign base_slot = start ? {pager_address[2:0], 1'b0} : slot_q;
	assign take      = active && item_s1.char_valid && (taken0 < MAX_CHARS);
	assign eot       = active && item_s1.message_end;

	// New bits, first sent in the highest place
	always_comb begin
		unique case ({take, eot})
			2'b11: begin
				seq    = {rev7(item_s1.text_char[6:0]), rev7(EOT_CHAR)};
				n_bits = 4'd14;
			end
			2'b10: begin
				seq    = {7'd0, rev7(item_s1.text_char[6:0])};
				n_bits = 4'd7;
			end
			2'b01: begin
				seq    = {7'd0, rev7(EOT_CHAR)};
				n_bits = 4'd7;
			end
			default: begin
				seq    = '0;
				n_bits = 4'd0;
			end
		endcase
	end

	// Append to the held bits and split off a full word
	assign acc        = ({14'd0, store0} << n_bits) | {20'd0, seq};
	assign l_len      = 6'(held0) + 6'(n_bits);
	assign full_e     = l_len >= 6'(WORD_BITS);
	assign rem_len    = 5'(full_e ? l_len - 6'(WORD_BITS) : l_len);
	assign full_data  = 20'(acc >> (l_len - 6'(WORD_BITS)));
	assign rem_bits   = 20'(acc & ((34'd1 << rem_len) - 34'd1));
	assign flush_e    = eot && (rem_len != 5'd0);
	assign flush_data = rem_bits << (5'(WORD_BITS) - rem_len);
	assign msg_a      = full_e ? full_data : flush_data;

	// Slots of the message words
	assign slot_full  = slot_inc(base_slot);
	assign slot_flush = slot_inc(full_e ? slot_full : base_slot);

	assign n_res = 2'(start) + 2'(full_e) + 2'(flush_e);

	// Codeword data for the two result places
	assign addr_data = {ADR_FLAG, pager_address[20:3], function_bits};
	assign data0     = start ? addr_data : {MSG_FLAG, msg_a};
	assign data1     = start ? {MSG_FLAG, msg_a} : {MSG_FLAG, flush_data};

	ptce_bch u_bch0 (.data(data0), .codeword(cw0));
	ptce_bch u_bch1 (.data(data1), .codeword(cw1));

	// Hand results to the queue
	always_comb begin
		wr.count             = adv ? n_res : 2'd0;
		wr.first.codeword    = cw0;
		wr.first.slot        = start ? base_slot : slot_full;
		wr.first.is_address  = start;
		wr.first.last_word   = eot && (n_res == 2'd1);
		wr.second.codeword   = cw1;
		wr.second.slot       = start ? slot_full : slot_flush;
		wr.second.is_address = 1'b0;
		wr.second.last_word  = eot && (n_res == 2'd2);
	end

	// Update message state; clear it at the end of the message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q  <= '0;
			held_q   <= '0;
			slot_q   <= '0;
			in_msg_q <= 1'b0;
			taken_q  <= '0;
		end else if (adv && active) begin
			if (eot) begin
				store_q  <= '0;
				held_q   <= '0;
				slot_q   <= '0;
				in_msg_q <= 1'b0;
				taken_q  <= '0;
			end else begin
				store_q  <= rem_bits;
				held_q   <= rem_len;
				slot_q   <= full_e ? slot_full : base_slot;
				in_msg_q <= 1'b1;
				taken_q  <= taken0 + 6'(take);
			end
		end
	end

	`PTCE_ASSERT_NEXT(a_end_clears, adv && eot, !in_msg_q && (held_q == 5'd0), "message state not cleared after end")
	`PTCE_ASSERT_IMPL(a_held_range, in_msg_q, held_q < 5'(WORD_BITS), "held bit count reached a full word")
	`PTCE_ASSERT_IMPL(a_last_final, wr.count == 2'd2, !wr.first.last_word, "last_word on a result that is not final")

endmodule

/* rtl/ptce_outq.sv */
// Four-entry result queue: takes up to two results a cycle, hands out one.
`include "pocsag_text_codeword_encoder_macros.svh"
module ptce_outq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ptce_pkg::ptce_wr_t    wr,
	output logic                  room,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ptce_pkg::ptce_result_t out_result
);
	import ptce_pkg::*;

	ptce_result_t entry_q [4];
	logic [1:0]   wr_ptr_q;
	logic [1:0]   rd_ptr_q;
	logic [2:0]   count_q;
	logic         pop;

	assign room       = count_q <= 3'd2;
	assign out_valid  = count_q != 3'd0;
	assign out_result = entry_q[rd_ptr_q];
	assign pop        = out_valid && out_ready;

	// Store incoming results in order
	always_ff @(posedge clk) begin
		if (wr.count != 2'd0) begin
			entry_q[wr_ptr_q] <= wr.first;
		end
		if (wr.count == 2'd2) begin
			entry_q[wr_ptr_q + 2'd1] <= wr.second;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + wr.count;
			rd_ptr_q <= rd_ptr_q + 2'(pop);
			count_q  <= count_q + 3'(wr.count) - 3'(pop);
		end
	end

	`PTCE_ASSERT_IMPL(a_push_room, wr.count != 2'd0, count_q <= 3'd2, "results written without room")
	`PTCE_ASSERT_IMPL(a_count_max, 1'b1, count_q <= 3'd4, "queue occupancy above depth")
	`PTCE_ASSERT_NEXT(a_pop_count, pop && (wr.count == 2'd0) && (count_q == 3'd1), !out_valid, "queue not empty after last item taken")

endmodule

/* rtl/pocsag_text_codeword_encoder.sv */
// Top level of the POCSAG text codeword encoder: ports, configuration registers, wiring.
//
// Takes message text one character per item and produces 32-bit POCSAG codewords
// (BCH(31,21) check bits plus even parity): the address codeword on the first item
// of a message, then message codewords of 20 text bits each, characters sent LSB
// first, with EOT appended and the last word zero-padded on the item that ends the
// message. One item is taken per clock while the queue has room; each result is
// built from the registered item and written into the output queue. An item makes
// zero, one or two codewords, and the master side hands out one codeword per cycle
// while m_tready is high from a four-entry queue, so items that make two codewords
// can hold up the input when the output runs at full speed. An item waits in the input
// register whenever the queue has fewer than two free entries. Write pager_address and
// function_bits only between messages; they are read when a message starts.
module pocsag_text_codeword_encoder #(
	parameter int unsigned MAX_TEXT_CHARS = 40
) (
	input  logic        clk,
	input  logic        arst_n,
	// Text input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] text_char
	input  logic        s_tuser,  // [0] char_valid
	input  logic        s_tlast,  // message_end
	// Codeword output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [31:0] codeword, [37:32] slot, [39:38] zero
	output logic        m_tuser,  // [0] is_address
	output logic        m_tlast,  // last_word
	// Configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [20:0] cfg_data
);
	import ptce_pkg::*;

	logic [20:0]  pager_address_q;
	logic [1:0]   function_bits_q;
	ptce_item_t   in_item;
	ptce_wr_t     wr;
	logic         room;
	ptce_result_t out_result;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pager_address_q <= '0;
			function_bits_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PAGER_ADDRESS: pager_address_q <= cfg_data;
				CFG_FUNCTION_BITS: function_bits_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign in_item.text_char   = s_tdata;
	assign in_item.char_valid  = s_tuser;
	assign in_item.message_end = s_tlast;

	ptce_pack #(
		.MAX_TEXT_CHARS(MAX_TEXT_CHARS)
	) u_pack (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_item      (in_item),
		.pager_address(pager_address_q),
		.function_bits(function_bits_q),
		.room         (room),
		.wr           (wr)
	);

	ptce_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_result(out_result)
	);

	assign m_tdata = {2'b00, out_result.slot, out_result.codeword};
	assign m_tuser = out_result.is_address;
	assign m_tlast = out_result.last_word;

endmodule
